// ----- src/cld_pkg.sv -----
package cld_pkg;

	localparam int CAPACITY    = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int VAL_W       = 32;
	localparam int ENTRY_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_BACK  = 2'd1,
		CMD_DELETE    = 2'd2,
		CMD_LIST      = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_ENTRY    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]              command;
		logic signed [VAL_W-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] entry_value;
		logic                    last;
		logic [ENTRY_CNT_W-1:0]  entry_count;
	} res_word_t;

	// in-use bitmap update
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} slot_upd_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        addr;
		logic signed [VAL_W-1:0] data;
	} val_wr_t;

endpackage

// ----- src/cld_ram.sv -----
module cld_ram #(
	parameter int WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [cld_pkg::IDX_W-1:0]   waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic [cld_pkg::IDX_W-1:0]   raddr,
	output logic [WIDTH-1:0]            rdata
);
	import cld_pkg::*;

	logic [WIDTH-1:0] mem [CAPACITY];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/cld_slot_map.sv -----
module cld_slot_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cld_pkg::slot_upd_t        slot_upd,
	output logic [cld_pkg::IDX_W-1:0] free_idx
);
	import cld_pkg::*;

	logic [CAPACITY-1:0] in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (slot_upd.set) begin
				in_use_q[slot_upd.idx] <= 1'b1;
			end
			if (slot_upd.clr) begin
				in_use_q[slot_upd.idx] <= 1'b0;
			end
		end
	end

	// lowest-numbered free slot; only used when the pool is not full
	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

endmodule

// ----- src/cld_ctrl.sv -----
module cld_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  cld_pkg::cmd_word_t               cmd_word,
	output logic                             res_strobe,
	output cld_pkg::res_word_t               res_word,
	input  logic [cld_pkg::IDX_W-1:0]        free_idx,
	output cld_pkg::slot_upd_t               slot_upd,
	output logic [cld_pkg::IDX_W-1:0]        rd_addr,
	input  logic signed [cld_pkg::VAL_W-1:0] value_rd,
	input  logic [cld_pkg::IDX_W-1:0]        next_rd,
	input  logic [cld_pkg::IDX_W-1:0]        prev_rd,
	output cld_pkg::val_wr_t                 val_wr,
	output cld_pkg::link_wr_t                next_wr,
	output cld_pkg::link_wr_t                prev_wr
);
	import cld_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISP     = 7'b0000010,
		S_INS_WR1  = 7'b0000100,
		S_INS_WR2  = 7'b0001000,
		S_WALK_DEL = 7'b0010000,
		S_WALK_LST = 7'b0100000,
		S_SPARE    = 7'b1000000
	} state_t;

	state_t             state_q, state_d;
	cmd_word_t          op_q, op_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   cur_q, cur_d;
	logic [IDX_W-1:0]   slot_q, slot_d;
	logic [IDX_W-1:0]   tail_q, tail_d;
	logic [CNT_W-1:0]   walk_q, walk_d;
	logic               strobe_q;
	res_word_t          res_q;

	logic                    emit;
	status_t                 emit_st;
	logic signed [VAL_W-1:0] emit_val;
	logic                    emit_last;
	logic [CNT_W-1:0]        emit_cnt;
	logic                    walk_end;
	logic                    pool_full;

	assign walk_end  = (walk_q + CNT_W'(1)) == count_q;
	assign pool_full = count_q == CNT_W'(CAPACITY);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		head_d    = head_q;
		count_d   = count_q;
		cur_d     = cur_q;
		slot_d    = slot_q;
		tail_d    = tail_q;
		walk_d    = walk_q;
		rd_addr   = cur_q;
		val_wr    = '0;
		next_wr   = '0;
		prev_wr   = '0;
		slot_upd  = '0;
		emit      = 1'b0;
		emit_st   = ST_DONE;
		emit_val  = op_q.value;
		emit_last = 1'b1;
		emit_cnt  = count_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d    = cmd_word;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cur_d   = head_q;
				rd_addr = head_q;
				slot_d  = free_idx;
				walk_d  = '0;
				case (op_q.command)
					CMD_INS_FRONT, CMD_INS_BACK: begin
						if (pool_full) begin
							emit    = 1'b1;
							emit_st = ST_FULL;
							state_d = S_IDLE;
						end else if (count_q == '0) begin
							// first entry links to itself
							val_wr.we     = 1'b1;
							val_wr.addr   = free_idx;
							val_wr.data   = op_q.value;
							next_wr.we    = 1'b1;
							next_wr.addr  = free_idx;
							next_wr.data  = free_idx;
							prev_wr.we    = 1'b1;
							prev_wr.addr  = free_idx;
							prev_wr.data  = free_idx;
							slot_upd.set  = 1'b1;
							slot_upd.idx  = free_idx;
							head_d        = free_idx;
							count_d       = CNT_W'(1);
							emit          = 1'b1;
							emit_cnt      = CNT_W'(1);
							state_d       = S_IDLE;
						end else begin
							// prev of head (the tail) is read this cycle
							state_d = S_INS_WR1;
						end
					end
					CMD_DELETE, CMD_LIST: begin
						if (count_q == '0) begin
							emit    = 1'b1;
							emit_st = ST_EMPTY;
							state_d = S_IDLE;
						end else if (op_q.command == CMD_DELETE) begin
							state_d = S_WALK_DEL;
						end else begin
							state_d = S_WALK_LST;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INS_WR1: begin
				val_wr.we    = 1'b1;
				val_wr.addr  = slot_q;
				val_wr.data  = op_q.value;
				next_wr.we   = 1'b1;
				next_wr.addr = slot_q;
				next_wr.data = head_q;
				prev_wr.we   = 1'b1;
				prev_wr.addr = slot_q;
				prev_wr.data = prev_rd;
				tail_d       = prev_rd;
				slot_upd.set = 1'b1;
				slot_upd.idx = slot_q;
				state_d      = S_INS_WR2;
			end
			S_INS_WR2: begin
				next_wr.we   = 1'b1;
				next_wr.addr = tail_q;
				next_wr.data = slot_q;
				prev_wr.we   = 1'b1;
				prev_wr.addr = head_q;
				prev_wr.data = slot_q;
				if (op_q.command == CMD_INS_FRONT) begin
					head_d = slot_q;
				end
				count_d  = count_q + CNT_W'(1);
				emit     = 1'b1;
				emit_cnt = count_q + CNT_W'(1);
				state_d  = S_IDLE;
			end
			S_WALK_DEL: begin
				if (value_rd == op_q.value) begin
					next_wr.we   = 1'b1;
					next_wr.addr = prev_rd;
					next_wr.data = next_rd;
					prev_wr.we   = 1'b1;
					prev_wr.addr = next_rd;
					prev_wr.data = prev_rd;
					slot_upd.clr = 1'b1;
					slot_upd.idx = cur_q;
					count_d      = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						head_d = '0;
					end else if (cur_q == head_q) begin
						head_d = next_rd;
					end
					emit     = 1'b1;
					emit_cnt = count_q - CNT_W'(1);
					state_d  = S_IDLE;
				end else if (walk_end) begin
					emit    = 1'b1;
					emit_st = ST_NOTFOUND;
					state_d = S_IDLE;
				end else begin
					walk_d  = walk_q + CNT_W'(1);
					cur_d   = next_rd;
					rd_addr = next_rd;
				end
			end
			S_WALK_LST: begin
				emit      = 1'b1;
				emit_st   = ST_ENTRY;
				emit_val  = value_rd;
				emit_last = walk_end;
				if (walk_end) begin
					state_d = S_IDLE;
				end else begin
					walk_d  = walk_q + CNT_W'(1);
					cur_d   = next_rd;
					rd_addr = next_rd;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		cur_q  <= cur_d;
		slot_q <= slot_d;
		tail_q <= tail_d;
		walk_q <= walk_d;
		if (emit) begin
			res_q.status      <= emit_st;
			res_q.entry_value <= emit_val;
			res_q.last        <= emit_last;
			res_q.entry_count <= ENTRY_CNT_W'(emit_cnt);
		end
	end

	assign busy       = state_q != S_IDLE;
	assign res_strobe = strobe_q;
	assign res_word   = res_q;

endmodule

// ----- src/circular_list_deque_core.sv -----
// Channel    Ports                      Handshake
// command    cmd_word (command, value)  taken when start is high and busy is low
// result     res_word (status, entry_value, last, entry_count)
//                                       valid for one cycle while res_strobe is high
//
// Every command passes through a dispatch state, then:
//   insert into an empty or full pool: result emitted from the dispatch state;
//   insert into a non-empty pool: tail read, then two link write states;
//   delete: a walk over k slots visited, k at most CAPACITY;
//   list of n entries: n results on consecutive cycles.
// The walk rate is one linked slot per cycle, set by the registered read of the
// link memories. Reset clears head, count and in-use map; slot memories need no
// clearing since only linked slots are read. Results cannot be stalled.
module circular_list_deque_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cld_pkg::cmd_word_t cmd_word,
	output logic               res_strobe,
	output cld_pkg::res_word_t res_word
);
	import cld_pkg::*;

	// link and value memories share one read address
	logic [IDX_W-1:0]        rd_addr;
	logic signed [VAL_W-1:0] value_rd;
	logic [IDX_W-1:0]        next_rd;
	logic [IDX_W-1:0]        prev_rd;
	val_wr_t                 val_wr;
	link_wr_t                next_wr;
	link_wr_t                prev_wr;

	// allocation
	slot_upd_t               slot_upd;
	logic [IDX_W-1:0]        free_idx;

	cld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd_word   (cmd_word),
		.res_strobe (res_strobe),
		.res_word   (res_word),
		.free_idx   (free_idx),
		.slot_upd   (slot_upd),
		.rd_addr    (rd_addr),
		.value_rd   (value_rd),
		.next_rd    (next_rd),
		.prev_rd    (prev_rd),
		.val_wr     (val_wr),
		.next_wr    (next_wr),
		.prev_wr    (prev_wr)
	);

	cld_slot_map u_slot_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.slot_upd (slot_upd),
		.free_idx (free_idx)
	);

	// slot values
	cld_ram #(.WIDTH(VAL_W)) u_value_ram (
		.clk   (clk),
		.we    (val_wr.we),
		.waddr (val_wr.addr),
		.wdata (val_wr.data),
		.raddr (rd_addr),
		.rdata (value_rd)
	);

	// forward links
	cld_ram #(.WIDTH(IDX_W)) u_next_ram (
		.clk   (clk),
		.we    (next_wr.we),
		.waddr (next_wr.addr),
		.wdata (next_wr.data),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	// backward links
	cld_ram #(.WIDTH(IDX_W)) u_prev_ram (
		.clk   (clk),
		.we    (prev_wr.we),
		.waddr (prev_wr.addr),
		.wdata (prev_wr.data),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

endmodule

// ----- src/cld_checker.sv -----
module cld_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               res_strobe,
	input cld_pkg::res_word_t res_word
);
	import cld_pkg::*;

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a listing continues on the very next cycle until its last word
	a_list_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !res_word.last |=> res_strobe)
		else $error("listing burst broken");

	// only listed entries may be non-final
	a_nonlast_entry: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !res_word.last |-> res_word.status == ST_ENTRY)
		else $error("non-final word with wrong status");

	// the final word leaves the block ready
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res_word.last |-> !busy)
		else $error("busy after final word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> res_word.entry_count <= CAPACITY)
		else $error("entry count beyond capacity");

endmodule

bind circular_list_deque_core cld_checker u_cld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.res_strobe (res_strobe),
	.res_word   (res_word)
);
